>>> rtl/blx_pkg.sv
`default_nettype none

package blx_pkg;

	localparam int unsigned GENE_W      = 32;
	localparam int unsigned FRAC_W      = 16;
	localparam int unsigned ALPHA_SHIFT = 12;
	localparam int unsigned WIDE_W      = GENE_W + FRAC_W - ALPHA_SHIFT;
	localparam int unsigned EXT_W       = WIDE_W + 2;
	localparam int unsigned IVL_STAGES  = 4;
	localparam int unsigned BLD_STAGES  = 2;
	localparam int unsigned NUM_STAGES  = IVL_STAGES + BLD_STAGES;

	localparam logic [FRAC_W-1:0] HALF_PICK    = 16'd32768;
	localparam logic [FRAC_W-1:0] ALPHA_RESET  = 16'd2048;
	localparam logic              BOUNDS_RESET = 1'b1;

	typedef enum logic {
		CFG_ALPHA  = 1'b0,
		CFG_BOUNDS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [GENE_W-1:0] first_parent;
		logic [GENE_W-1:0] second_parent;
		logic [GENE_W-1:0] lower_bound;
		logic [GENE_W-1:0] upper_bound;
		logic              may_change;
		logic [FRAC_W-1:0] pick_fraction;
		logic [FRAC_W-1:0] blend_fraction;
	} gene_in_t;

	typedef struct packed {
		logic [GENE_W-1:0] ivl_lo;
		logic [GENE_W-1:0] ivl_hi;
		logic [GENE_W-1:0] keep_val;
		logic              may_change;
		logic [FRAC_W-1:0] blend_fraction;
	} ivl_t;

endpackage

`default_nettype wire

>>> rtl/blx_interval.sv
`default_nettype none

module blx_interval
	import blx_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [IVL_STAGES-1:0] en,
	input  wire gene_in_t              gene,
	input  wire logic [FRAC_W-1:0]     alpha_scale,
	input  wire logic                  bounds_enabled,
	output ivl_t                       ivl
);

	localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(64'sd2147483647);
	localparam logic signed [EXT_W-1:0] SAT_MIN = -EXT_W'(64'sd2147483648);

	// stage 1: order parents, take the span, choose the fixed-gene parent
	logic              swap;
	logic [GENE_W-1:0] lo_s1, hi_s1, diff_s1, lb_s1, ub_s1, keep_s1;
	logic              chg_s1;
	logic [FRAC_W-1:0] blend_s1;

	assign swap = $signed(gene.second_parent) < $signed(gene.first_parent);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			lo_s1    <= swap ? gene.second_parent : gene.first_parent;
			hi_s1    <= swap ? gene.first_parent : gene.second_parent;
			diff_s1  <= swap ? (gene.first_parent - gene.second_parent)
			                 : (gene.second_parent - gene.first_parent);
			lb_s1    <= gene.lower_bound;
			ub_s1    <= gene.upper_bound;
			keep_s1  <= (gene.pick_fraction <= HALF_PICK) ? gene.first_parent
			                                              : gene.second_parent;
			chg_s1   <= gene.may_change;
			blend_s1 <= gene.blend_fraction;
		end
	end

	// stage 2: widening = floor(span * alpha / 4096)
	logic [GENE_W+FRAC_W-1:0] wprod;
	logic [WIDE_W-1:0]        widen_s2;
	logic [GENE_W-1:0]        lo_s2, hi_s2, lb_s2, ub_s2, keep_s2;
	logic                     chg_s2;
	logic [FRAC_W-1:0]        blend_s2;

	assign wprod = {{FRAC_W{1'b0}}, diff_s1} * {{GENE_W{1'b0}}, alpha_scale};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			widen_s2 <= wprod[GENE_W+FRAC_W-1:ALPHA_SHIFT];
			lo_s2    <= lo_s1;
			hi_s2    <= hi_s1;
			lb_s2    <= lb_s1;
			ub_s2    <= ub_s1;
			keep_s2  <= keep_s1;
			chg_s2   <= chg_s1;
			blend_s2 <= blend_s1;
		end
	end

	// stage 3: exact interval ends
	logic [EXT_W-1:0]  a_s3, b_s3;
	logic [GENE_W-1:0] lb_s3, ub_s3, keep_s3;
	logic              chg_s3;
	logic [FRAC_W-1:0] blend_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			a_s3     <= {{(EXT_W-GENE_W){lo_s2[GENE_W-1]}}, lo_s2} - {2'b00, widen_s2};
			b_s3     <= {{(EXT_W-GENE_W){hi_s2[GENE_W-1]}}, hi_s2} + {2'b00, widen_s2};
			lb_s3    <= lb_s2;
			ub_s3    <= ub_s2;
			keep_s3  <= keep_s2;
			chg_s3   <= chg_s2;
			blend_s3 <= blend_s2;
		end
	end

	// stage 4: clamp to the bounds when they are enabled, then saturate to 32 bits
	logic signed [EXT_W-1:0] lb_ext, ub_ext, a_cl, b_cl;
	logic [GENE_W-1:0]       a_sat, b_sat;
	ivl_t                    ivl_s4;

	assign lb_ext = $signed({{(EXT_W-GENE_W){lb_s3[GENE_W-1]}}, lb_s3});
	assign ub_ext = $signed({{(EXT_W-GENE_W){ub_s3[GENE_W-1]}}, ub_s3});

	always_comb begin
		a_cl = $signed(a_s3);
		b_cl = $signed(b_s3);
		if (bounds_enabled && (a_cl < lb_ext)) a_cl = lb_ext;
		if (bounds_enabled && (b_cl > ub_ext)) b_cl = ub_ext;
		if (a_cl > SAT_MAX)      a_sat = SAT_MAX[GENE_W-1:0];
		else if (a_cl < SAT_MIN) a_sat = SAT_MIN[GENE_W-1:0];
		else                     a_sat = a_cl[GENE_W-1:0];
		if (b_cl > SAT_MAX)      b_sat = SAT_MAX[GENE_W-1:0];
		else if (b_cl < SAT_MIN) b_sat = SAT_MIN[GENE_W-1:0];
		else                     b_sat = b_cl[GENE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ivl_s4.ivl_lo         <= a_sat;
			ivl_s4.ivl_hi         <= b_sat;
			ivl_s4.keep_val       <= keep_s3;
			ivl_s4.may_change     <= chg_s3;
			ivl_s4.blend_fraction <= blend_s3;
		end
	end

	assign ivl = ivl_s4;

endmodule

`default_nettype wire

>>> rtl/blx_blend.sv
`default_nettype none

module blx_blend
	import blx_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [BLD_STAGES-1:0] en,
	input  wire ivl_t                  ivl,
	output logic [GENE_W-1:0]          child_gene
);

	// stage 5: signed offset = floor((B - A) * blend / 65536)
	logic signed [GENE_W:0]          span;
	logic signed [FRAC_W:0]          blend_sx;
	logic signed [GENE_W+FRAC_W+1:0] bprod;
	logic [GENE_W-1:0]               offs_s5, a_s5, keep_s5;
	logic                            chg_s5;

	assign span     = $signed({ivl.ivl_hi[GENE_W-1], ivl.ivl_hi})
	                - $signed({ivl.ivl_lo[GENE_W-1], ivl.ivl_lo});
	assign blend_sx = $signed({1'b0, ivl.blend_fraction});
	assign bprod    = span * blend_sx;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			offs_s5 <= bprod[GENE_W+FRAC_W-1:FRAC_W];
			a_s5    <= ivl.ivl_lo;
			keep_s5 <= ivl.keep_val;
			chg_s5  <= ivl.may_change;
		end
	end

	// stage 6: place the child or copy the chosen parent
	logic [GENE_W-1:0] child_s6;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			child_s6 <= chg_s5 ? (a_s5 + offs_s5) : keep_s5;
		end
	end

	assign child_gene = child_s6;

endmodule

`default_nettype wire

>>> rtl/blx_alpha_gene_crossover.sv
// Each accepted input word passes through the interval and blend stages to its output word.
// Throughput: one word per cycle; a stalled output holds the pipeline and
// empty stages still fill, so no word is lost or repeated.
// Reset (arst_n low, asynchronous): all stage valid bits clear,
// alpha_scale returns to 2048 and bounds_enabled to 1.
`default_nettype none

module blx_alpha_gene_crossover
	import blx_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: first_parent[31:0], second_parent[63:32], lower_bound[95:64],
	//        upper_bound[127:96], pick_fraction[143:128], blend_fraction[159:144]
	input  wire logic [159:0] s_axis_tdata,
	// tuser: may_change[0]
	input  wire logic         s_axis_tuser,
	// output stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: child_gene[31:0]
	output logic [31:0]       m_axis_tdata,
	// configuration write channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_data
);

	// Stage valid bits, declared here since the configuration ready uses them.
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0]   adv;

	// Configuration registers. Accept a write only while the pipeline is
	// drained and no input word is offered, so the stages read them directly.
	logic [FRAC_W-1:0] alpha_q;
	logic              bounds_q;

	assign cfg_ready = !(|vld_q) && !s_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RESET;
			bounds_q <= BOUNDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ALPHA:  alpha_q  <= cfg_data;
				CFG_BOUNDS: bounds_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// Stage valid bits. A stage advances when it is empty or when the stage
	// after it advances, so bubbles collapse under a stalled output.
	always_comb begin
		adv[NUM_STAGES] = m_axis_tready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= s_axis_tvalid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_axis_tready = adv[0];
	assign m_axis_tvalid = vld_q[NUM_STAGES-1];

	// Unpack the input word.
	gene_in_t gene;

	assign gene.first_parent   = s_axis_tdata[31:0];
	assign gene.second_parent  = s_axis_tdata[63:32];
	assign gene.lower_bound    = s_axis_tdata[95:64];
	assign gene.upper_bound    = s_axis_tdata[127:96];
	assign gene.pick_fraction  = s_axis_tdata[143:128];
	assign gene.blend_fraction = s_axis_tdata[159:144];
	assign gene.may_change     = s_axis_tuser;

	// Stages 1-4: order, widen, extend, clamp and saturate the interval.
	ivl_t ivl;

	blx_interval u_interval (
		.clk            (clk),
		.en             (adv[IVL_STAGES-1:0]),
		.gene           (gene),
		.alpha_scale    (alpha_q),
		.bounds_enabled (bounds_q),
		.ivl            (ivl)
	);

	// Stages 5-6: blend inside the interval, or pass the chosen parent.
	blx_blend u_blend (
		.clk        (clk),
		.en         (adv[NUM_STAGES-1:IVL_STAGES]),
		.ivl        (ivl),
		.child_gene (m_axis_tdata)
	);

endmodule

`default_nettype wire
